// ----- hdl/dual_serial_channel_controller_unit_assert.svh -----
// Assertion macros for the dual serial channel controller.
// Used by the top level; depends on clk and rst_n being in scope.
`ifndef DUAL_SERIAL_CHANNEL_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_SERIAL_CHANNEL_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DSCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dscc assertion failed");
`define DSCC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dscc forbidden condition");
`else
`define DSCC_ASSERT(lbl, prop)
`define DSCC_NEVER(lbl, expr)
`endif
`endif

// ----- hdl/dscc_pkg.sv -----
// Package for the dual serial channel controller: codes, constants, types.
// No dependencies.
package dscc_pkg;

    localparam int DSCC_FIFO_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    localparam logic REG_TX_DELAY = 1'b0;
    localparam logic REG_RX_DELAY = 1'b1;

    localparam logic [2:0] PTR_RR0 = 3'd0;
    localparam logic [2:0] PTR_RR1 = 3'd1;
    localparam logic [2:0] PTR_RR2 = 3'd2;
    localparam logic [2:0] PTR_MASK = 3'd7;

    localparam logic [7:0] VEC_BASE_MASK = 8'hfe;
    localparam logic [7:0] VEC_HI_MASK   = 8'hf0;
    localparam logic [7:0] RX_IE_MASK    = 8'h18;
    localparam logic [7:0] RR0_RX_AVAIL  = 8'h01;
    localparam logic [7:0] RR0_TX_EMPTY  = 8'h04;
    localparam logic [7:0] RR_UNUSED     = 8'hff;
    localparam logic [7:0] VEC_TX_A      = 8'h08;
    localparam logic [7:0] VEC_TX_B      = 8'h00;
    localparam logic [7:0] VEC_RX_A      = 8'h0c;
    localparam logic [7:0] VEC_RX_B      = 8'h04;

    // Bits of write register 1
    localparam int WR1_TX_IE  = 1;
    localparam int WR1_VEC_LO = 2;

    typedef struct packed {
        logic       rd_pop;
        logic [7:0] rd_const;
        logic [1:0] txv;
        logic       pulse;
        logic [1:0] xfer;
    } res_t;

endpackage

// ----- hdl/dscc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hdl/dscc_ctrl.sv -----
// Front stage: pointers, write registers, FIFO heads and counts, timers, vector.
// Depends on dscc_pkg; drives the FIFO RAM addresses and the per-word result flags.
module dscc_ctrl #(
    parameter int FIFO_DEPTH = dscc_pkg::DSCC_FIFO_DEPTH,
    parameter int SW = $clog2(FIFO_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 fire,
    input  logic [1:0]           command,
    input  logic                 channel,
    input  logic                 control_select,
    input  logic [7:0]           data_in,
    output logic [1:0][SW-1:0]   tx_head,
    output logic [1:0][SW-1:0]   stg_head,
    output logic [1:0][SW-1:0]   rx_head,
    output logic [SW-1:0]        push_slot,
    output logic [1:0]           tx_we,
    output logic [1:0]           stg_we,
    output logic [1:0][SW-1:0]   rx_wslot,
    output dscc_pkg::res_t       res
);
    import dscc_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);

    logic [15:0] tx_delay_reg, rx_delay_reg;
    logic [15:0] tx_delay_eff, rx_delay_eff;

    logic [1:0][2:0]    ptr_reg, ptr_next;
    logic [1:0][7:0]    wr1_reg, wr1_next;
    logic [7:0]         vbase_reg, vbase_next;
    logic [7:0]         vec_reg, vec_next;
    logic [1:0][SW-1:0] txh_reg, txh_next, rxh_reg, rxh_next, sgh_reg, sgh_next;
    logic [1:0][CW-1:0] txc_reg, txc_next, rxc_reg, rxc_next, sgc_reg, sgc_next;
    logic [3:0][15:0]   cd_reg, cd_next;
    logic [3:0]         arm_reg, arm_next;
    logic [2:0]         p;

    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h, input logic [CW-1:0] n);
        logic [SW:0] s;
        s = {1'b0, h} + (SW+1)'(n);
        if (s >= (SW+1)'(FIFO_DEPTH))
        begin
            s = s - (SW+1)'(FIFO_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] inc(input logic [SW-1:0] h);
        return (h == SW'(FIFO_DEPTH - 1)) ? '0 : h + SW'(1);
    endfunction

    function automatic logic [7:0] vec_of(input logic [7:0] base, input logic [7:0] wr1,
                                          input logic [7:0] lo);
        logic [7:0] v;
        v = base & VEC_BASE_MASK;
        if (wr1[WR1_VEC_LO])
        begin
            v = (v & VEC_HI_MASK) | lo;
        end
        return v;
    endfunction

    assign tx_delay_eff = (tx_delay_reg == '0) ? 16'd1 : tx_delay_reg;
    assign rx_delay_eff = (rx_delay_reg == '0) ? 16'd1 : rx_delay_reg;
    assign tx_head  = txh_reg;
    assign stg_head = sgh_reg;
    assign rx_head  = rxh_reg;
    assign p        = ptr_reg[channel] & PTR_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_delay_reg <= 16'd1;
            rx_delay_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TX_DELAY: tx_delay_reg <= cfg_data;
                REG_RX_DELAY: rx_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ptr_next  = ptr_reg;
        wr1_next  = wr1_reg;
        vbase_next = vbase_reg;
        vec_next  = vec_reg;
        txh_next  = txh_reg;
        rxh_next  = rxh_reg;
        sgh_next  = sgh_reg;
        txc_next  = txc_reg;
        rxc_next  = rxc_reg;
        sgc_next  = sgc_reg;
        cd_next   = cd_reg;
        arm_next  = arm_reg;
        res       = '0;
        tx_we     = '0;
        stg_we    = '0;
        rx_wslot  = '0;
        push_slot = '0;
        if (fire)
        begin
            unique case (cmd_t'(command))
                CMD_WRITE:
                begin
                    if (!control_select)
                    begin
                        push_slot = slot_of(txh_reg[channel], txc_reg[channel]);
                        if (txc_reg[channel] != CNT_FULL)
                        begin
                            tx_we[channel]    = 1'b1;
                            txc_next[channel] = txc_reg[channel] + CNT_ONE;
                        end
                        if (!arm_reg[channel])
                        begin
                            arm_next[channel] = 1'b1;
                            cd_next[channel]  = tx_delay_eff;
                        end
                    end
                    else
                    begin
                        if (p == PTR_RR1)
                        begin
                            wr1_next[channel] = data_in;
                        end
                        if (p == PTR_RR2 && channel)
                        begin
                            vbase_next = data_in;
                        end
                        ptr_next[channel] = (p == PTR_RR0) ? (data_in[2:0] & PTR_MASK) : PTR_RR0;
                    end
                end
                CMD_READ:
                begin
                    if (!control_select)
                    begin
                        if (rxc_reg[channel] != '0)
                        begin
                            res.rd_pop        = 1'b1;
                            rxh_next[channel] = inc(rxh_reg[channel]);
                            rxc_next[channel] = rxc_reg[channel] - CNT_ONE;
                        end
                    end
                    else
                    begin
                        unique case (p)
                            PTR_RR0:
                            begin
                                res.rd_const = ((rxc_reg[channel] != '0) ? RR0_RX_AVAIL : 8'h00)
                                             | ((txc_reg[channel] == '0) ? RR0_TX_EMPTY : 8'h00);
                            end
                            PTR_RR1: res.rd_const = (txc_reg[channel] == '0) ? 8'h01 : 8'h00;
                            PTR_RR2: res.rd_const = vec_reg;
                            default: res.rd_const = RR_UNUSED;
                        endcase
                        if (p != PTR_RR0)
                        begin
                            ptr_next[channel] = PTR_RR0;
                        end
                    end
                end
                CMD_RECV:
                begin
                    push_slot = slot_of(sgh_reg[channel], sgc_reg[channel]);
                    if (sgc_reg[channel] != CNT_FULL)
                    begin
                        stg_we[channel]   = 1'b1;
                        sgc_next[channel] = sgc_reg[channel] + CNT_ONE;
                    end
                    if (!arm_reg[2 + int'(channel)])
                    begin
                        arm_next[2 + int'(channel)] = 1'b1;
                        cd_next[2 + int'(channel)]  = rx_delay_eff;
                    end
                end
                CMD_TICK:
                begin
                    // transmit timers, A then B
                    for (int c = 0; c < 2; c++)
                    begin
                        if (arm_reg[c])
                        begin
                            if (cd_reg[c] > 16'd1)
                            begin
                                cd_next[c] = cd_reg[c] - 16'd1;
                            end
                            else
                            begin
                                arm_next[c] = 1'b0;
                                cd_next[c]  = '0;
                                if (txc_reg[c] != '0)
                                begin
                                    res.txv[c]  = 1'b1;
                                    txh_next[c] = inc(txh_reg[c]);
                                    txc_next[c] = txc_reg[c] - CNT_ONE;
                                end
                                if (wr1_reg[c][WR1_TX_IE])
                                begin
                                    vec_next  = vec_of(vbase_reg, wr1_reg[c],
                                                       (c == 0) ? VEC_TX_A : VEC_TX_B);
                                    res.pulse = 1'b1;
                                end
                                if (txc_next[c] != '0)
                                begin
                                    arm_next[c] = 1'b1;
                                    cd_next[c]  = tx_delay_eff;
                                end
                            end
                        end
                    end
                    // receive timers, A then B
                    for (int c = 0; c < 2; c++)
                    begin
                        if (arm_reg[2 + c])
                        begin
                            if (cd_reg[2 + c] > 16'd1)
                            begin
                                cd_next[2 + c] = cd_reg[2 + c] - 16'd1;
                            end
                            else
                            begin
                                arm_next[2 + c] = 1'b0;
                                cd_next[2 + c]  = '0;
                                if (sgc_reg[c] != '0)
                                begin
                                    sgh_next[c] = inc(sgh_reg[c]);
                                    sgc_next[c] = sgc_reg[c] - CNT_ONE;
                                    if (rxc_reg[c] != CNT_FULL)
                                    begin
                                        res.xfer[c] = 1'b1;
                                        rx_wslot[c] = slot_of(rxh_reg[c], rxc_reg[c]);
                                        rxc_next[c] = rxc_reg[c] + CNT_ONE;
                                    end
                                    if ((wr1_reg[c] & RX_IE_MASK) != 8'h00)
                                    begin
                                        vec_next  = vec_of(vbase_reg, wr1_reg[c],
                                                           (c == 0) ? VEC_RX_A : VEC_RX_B);
                                        res.pulse = 1'b1;
                                    end
                                end
                                if (sgc_next[c] != '0)
                                begin
                                    arm_next[2 + c] = 1'b1;
                                    cd_next[2 + c]  = rx_delay_eff;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            wr1_reg   <= '0;
            vbase_reg <= '0;
            vec_reg   <= '0;
            txh_reg   <= '0;
            rxh_reg   <= '0;
            sgh_reg   <= '0;
            txc_reg   <= '0;
            rxc_reg   <= '0;
            sgc_reg   <= '0;
            cd_reg    <= '0;
            arm_reg   <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            wr1_reg   <= wr1_next;
            vbase_reg <= vbase_next;
            vec_reg   <= vec_next;
            txh_reg   <= txh_next;
            rxh_reg   <= rxh_next;
            sgh_reg   <= sgh_next;
            txc_reg   <= txc_next;
            rxc_reg   <= rxc_next;
            sgc_reg   <= sgc_next;
            cd_reg    <= cd_next;
            arm_reg   <= arm_next;
        end
    end
endmodule

// ----- hdl/dual_serial_channel_controller_unit.sv -----
// Top level of the dual serial channel controller.
// Depends on dscc_pkg, dscc_ctrl, dscc_ram and the assertion header.
//
// Usage:
//   Input words (item_valid/item_ready) carry a command: bus write, bus read,
//   received serial byte, or one time tick, with channel, control_select and
//   data_in. Every input word yields exactly one result word
//   (result_valid/result_ready): read data, per-channel transmit bytes and
//   an interrupt pulse.
//   Configuration (cfg_write, cfg_index, cfg_data) sets the transmit and
//   receive delays in ticks; write it only while no word is in flight.
// Timing:
//   One word per cycle sustained while results are taken. A result appears in
//   the cycle after its input word is taken, the registered FIFO RAM read.
//   A tick moving a staged byte writes the receive RAM in the result cycle;
//   a bus pop of that same slot in the next word is forwarded.
// Reset:
//   rst_n clears pointers, registers, FIFO counts, timers and the vector;
//   delays return to one tick. RAM contents are not cleared.
// Stall:
//   While a result waits, item_ready follows result_ready, so the single
//   result register holds and nothing is lost.
module dual_serial_channel_controller_unit #(
    parameter int FIFO_DEPTH = dscc_pkg::DSCC_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  command,
    input  logic        channel,
    input  logic        control_select,
    input  logic [7:0]  data_in,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic        tx_a_valid,
    output logic [7:0]  tx_a_byte,
    output logic        tx_b_valid,
    output logic [7:0]  tx_b_byte,
    output logic        interrupt_pulse
);
    import dscc_pkg::*;

    `include "dual_serial_channel_controller_unit_assert.svh"

    localparam int SW = $clog2(FIFO_DEPTH);

    logic               item_fire;
    logic [1:0][SW-1:0] tx_head, stg_head, rx_head, rx_wslot;
    logic [SW-1:0]      push_slot;
    logic [1:0]         tx_we, stg_we, rx_we;
    res_t               res;
    logic [1:0][7:0]    tx_rdata, stg_rdata, rx_rdata;

    // result stage
    logic               s1_valid_reg, s1_new_reg;
    res_t               s1_res_reg;
    logic [1:0][SW-1:0] s1_wslot_reg;
    logic               s1_ch_reg;
    logic               s1_fwd_reg, fwd_hit;
    logic [7:0]         s1_fwd_data_reg;

    assign item_ready = !s1_valid_reg || result_ready;
    assign item_fire  = item_valid && item_ready;

    dscc_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .SW         (SW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fire           (item_fire),
        .command        (command),
        .channel        (channel),
        .control_select (control_select),
        .data_in        (data_in),
        .tx_head        (tx_head),
        .stg_head       (stg_head),
        .rx_head        (rx_head),
        .push_slot      (push_slot),
        .tx_we          (tx_we),
        .stg_we         (stg_we),
        .rx_wslot       (rx_wslot),
        .res            (res)
    );

    // Staged-to-receive moves land in the receive RAM during the first
    // cycle of the result stage, using the staging read data.
    for (genvar c = 0; c < 2; c++)
    begin : g_chan
        assign rx_we[c] = s1_valid_reg && s1_new_reg && s1_res_reg.xfer[c];

        dscc_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
            .clk   (clk),
            .we    (tx_we[c]),
            .waddr (push_slot),
            .wdata (data_in),
            .re    (item_fire),
            .raddr (tx_head[c]),
            .rdata (tx_rdata[c])
        );

        dscc_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_stg_ram (
            .clk   (clk),
            .we    (stg_we[c]),
            .waddr (push_slot),
            .wdata (data_in),
            .re    (item_fire),
            .raddr (stg_head[c]),
            .rdata (stg_rdata[c])
        );

        dscc_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
            .clk   (clk),
            .we    (rx_we[c]),
            .waddr (s1_wslot_reg[c]),
            .wdata (stg_rdata[c]),
            .re    (item_fire),
            .raddr (rx_head[c]),
            .rdata (rx_rdata[c])
        );
    end

    // pop reads the slot being written this very cycle
    assign fwd_hit = res.rd_pop && rx_we[channel] && (s1_wslot_reg[channel] == rx_head[channel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_new_reg   <= 1'b0;
        end
        else
        begin
            s1_new_reg <= item_fire;
            if (item_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_res_reg      <= res;
            s1_wslot_reg    <= rx_wslot;
            s1_ch_reg       <= channel;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= stg_rdata[channel];
        end
    end

    assign result_valid    = s1_valid_reg;
    assign read_data       = s1_res_reg.rd_pop
                           ? (s1_fwd_reg ? s1_fwd_data_reg : rx_rdata[s1_ch_reg])
                           : s1_res_reg.rd_const;
    assign tx_a_valid      = s1_res_reg.txv[0];
    assign tx_a_byte       = s1_res_reg.txv[0] ? tx_rdata[0] : 8'h00;
    assign tx_b_valid      = s1_res_reg.txv[1];
    assign tx_b_byte       = s1_res_reg.txv[1] ? tx_rdata[1] : 8'h00;
    assign interrupt_pulse = s1_res_reg.pulse;

    `DSCC_ASSERT(a_rx_write_once, (rx_we != 2'b00) |-> $past(item_fire))
    `DSCC_ASSERT(a_fwd_only_pop, (s1_valid_reg && s1_fwd_reg) |-> s1_res_reg.rd_pop)
    `DSCC_NEVER(a_stall_blocks, s1_valid_reg && !result_ready && item_ready)
endmodule

// ----- dv/dual_serial_channel_controller_unit_tb.sv -----
// Self-checking bench for the dual serial channel controller unit.
// Depends on dscc_pkg and the dual_serial_channel_controller_unit RTL.
// Directed rows, a full-FIFO run, then constrained-by-hand random words, checked against a local predictor.
module dual_serial_channel_controller_unit_tb;
    import dscc_pkg::*;

    localparam int DEPTH = DSCC_FIFO_DEPTH;
    localparam int WATCHDOG_LIMIT = 400000;

    // Fixed value meaning "not typed in, use the predictor" for directed rows
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic       chan;
        logic       ctl;
        logic [7:0] data;
    } word_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       txav;
        logic [7:0] txab;
        logic       txbv;
        logic [7:0] txbb;
        logic       irq;
    } outcome_t;

    typedef struct packed {
        word_t    w;
        logic     typed;
        outcome_t exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  command = '0;
    logic        channel = 1'b0;
    logic        control_select = 1'b0;
    logic [7:0]  data_in = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  read_data;
    logic        tx_a_valid;
    logic [7:0]  tx_a_byte;
    logic        tx_b_valid;
    logic [7:0]  tx_b_byte;
    logic        interrupt_pulse;

    dual_serial_channel_controller_unit dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---- predictor state ----
    logic [15:0] p_tx_delay, p_rx_delay;
    logic [2:0]  p_ptr [2];
    logic [7:0]  p_wr [16];
    logic [7:0]  p_vec;
    logic [7:0]  p_mem [3][2][DEPTH];
    int          p_head [3][2];
    int          p_cnt [3][2];
    logic [15:0] p_cd [4];
    logic        p_armed [4];

    outcome_t expected_q [$];
    int  errors = 0;
    int  idle_pct = 26;
    bit  hold_off = 0;

    task automatic predictor_reset();
        p_tx_delay = 16'd1;
        p_rx_delay = 16'd1;
        p_vec = '0;
        for (int i = 0; i < 16; i++) p_wr[i] = '0;
        for (int c = 0; c < 2; c++)
        begin
            p_ptr[c] = '0;
            for (int k = 0; k < 3; k++)
            begin
                p_head[k][c] = 0;
                p_cnt[k][c] = 0;
            end
        end
        for (int t = 0; t < 4; t++)
        begin
            p_cd[t] = '0;
            p_armed[t] = 1'b0;
        end
    endtask

    // kind: 0 transmit, 1 receive, 2 staging
    function automatic void fifo_in(int kind, int c, logic [7:0] v);
        if (p_cnt[kind][c] < DEPTH)
        begin
            p_mem[kind][c][(p_head[kind][c] + p_cnt[kind][c]) % DEPTH] = v;
            p_cnt[kind][c]++;
        end
    endfunction

    function automatic logic [7:0] fifo_out(int kind, int c);
        logic [7:0] v;
        if (p_cnt[kind][c] == 0) return 8'h00;
        v = p_mem[kind][c][p_head[kind][c]];
        p_head[kind][c] = (p_head[kind][c] + 1) % DEPTH;
        p_cnt[kind][c]--;
        return v;
    endfunction

    function automatic void arm_timer(int t, logic [15:0] d);
        if (!p_armed[t])
        begin
            p_armed[t] = 1'b1;
            p_cd[t] = (d == 0) ? 16'd1 : d;
        end
    endfunction

    function automatic void load_vector(int c, logic [7:0] lo_a, logic [7:0] lo_b);
        p_vec = p_wr[8 + 2] & VEC_BASE_MASK;
        if (p_wr[c * 8 + 1][WR1_VEC_LO])
            p_vec = (p_vec & VEC_HI_MASK) | (c ? lo_b : lo_a);
    endfunction

    function automatic outcome_t controller_step(word_t w);
        outcome_t o;
        logic [2:0] p;
        int c;
        o = '0;
        c = w.chan;
        case (cmd_t'(w.cmd))
            CMD_WRITE:
                if (!w.ctl)
                begin
                    fifo_in(0, c, w.data);
                    arm_timer(c, p_tx_delay);
                end
                else
                begin
                    p = p_ptr[c];
                    p_wr[c * 8 + p] = w.data;
                    p_ptr[c] = (p == PTR_RR0) ? (w.data[2:0] & PTR_MASK) : PTR_RR0;
                end
            CMD_READ:
                if (!w.ctl)
                    o.rd = fifo_out(1, c);
                else
                begin
                    p = p_ptr[c];
                    if (p == PTR_RR0)
                        o.rd = ((p_cnt[1][c] != 0) ? RR0_RX_AVAIL : 8'h00)
                             | ((p_cnt[0][c] == 0) ? RR0_TX_EMPTY : 8'h00);
                    else
                    begin
                        if (p == PTR_RR1) o.rd = (p_cnt[0][c] == 0) ? 8'h01 : 8'h00;
                        else if (p == PTR_RR2) o.rd = p_vec;
                        else o.rd = RR_UNUSED;
                        p_ptr[c] = PTR_RR0;
                    end
                end
            CMD_RECV:
            begin
                fifo_in(2, c, w.data);
                arm_timer(2 + c, p_rx_delay);
            end
            default:
                for (int t = 0; t < 4; t++)
                begin
                    if (!p_armed[t]) continue;
                    if (p_cd[t] > 0) p_cd[t]--;
                    if (p_cd[t] != 0) continue;
                    p_armed[t] = 1'b0;
                    c = t & 1;
                    if (t < 2)
                    begin
                        if (p_cnt[0][c] != 0)
                        begin
                            if (c == 0)
                            begin
                                o.txav = 1'b1;
                                o.txab = fifo_out(0, 0);
                            end
                            else
                            begin
                                o.txbv = 1'b1;
                                o.txbb = fifo_out(0, 1);
                            end
                        end
                        if (p_wr[c * 8 + 1][WR1_TX_IE])
                        begin
                            load_vector(c, VEC_TX_A, VEC_TX_B);
                            o.irq = 1'b1;
                        end
                        if (p_cnt[0][c] != 0) arm_timer(t, p_tx_delay);
                    end
                    else
                    begin
                        if (p_cnt[2][c] != 0)
                        begin
                            fifo_in(1, c, fifo_out(2, c));
                            if ((p_wr[c * 8 + 1] & RX_IE_MASK) != 0)
                            begin
                                load_vector(c, VEC_RX_A, VEC_RX_B);
                                o.irq = 1'b1;
                            end
                        end
                        if (p_cnt[2][c] != 0) arm_timer(t, p_rx_delay);
                    end
                end
        endcase
        return o;
    endfunction

    // ---- result checking (rising edge) ----
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                outcome_t e;
                e = expected_q.pop_front();
                if (read_data !== e.rd)
                begin
                    $error("read_data exp %0h got %0h", e.rd, read_data);
                    errors++;
                end
                if (tx_a_valid !== e.txav)
                begin
                    $error("tx_a_valid exp %0h got %0h", e.txav, tx_a_valid);
                    errors++;
                end
                if (tx_a_byte !== e.txab)
                begin
                    $error("tx_a_byte exp %0h got %0h", e.txab, tx_a_byte);
                    errors++;
                end
                if (tx_b_valid !== e.txbv)
                begin
                    $error("tx_b_valid exp %0h got %0h", e.txbv, tx_b_valid);
                    errors++;
                end
                if (tx_b_byte !== e.txbb)
                begin
                    $error("tx_b_byte exp %0h got %0h", e.txbb, tx_b_byte);
                    errors++;
                end
                if (interrupt_pulse !== e.irq)
                begin
                    $error("interrupt_pulse exp %0h got %0h", e.irq, interrupt_pulse);
                    errors++;
                end
            end
        end
    end

    // ---- receiver stalls, changed at the falling edge ----
    always @(negedge clk)
        result_ready <= hold_off ? 1'b1 : ($urandom_range(99) >= idle_pct);

    // ---- watchdog: cycles with nothing accepted ----
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAIL dual_serial_channel_controller_unit");
            $finish;
        end
    end

    // Send one word: optional gap with valid low, then hold valid until taken.
    // Valid stays high on return so back-to-back words need no extra edge.
    // The expected result is queued at the accepting edge.
    task automatic send_word(word_t w, logic typed, outcome_t typed_exp);
        outcome_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        command        <= w.cmd;
        channel        <= w.chan;
        control_select <= w.ctl;
        data_in        <= w.data;
        item_valid     <= 1'b1;
        do @(posedge clk); while (!item_ready);
        pred = controller_step(w);
        if (typed && pred !== typed_exp)
        begin
            $error("directed row: typed %0h predictor %0h", typed_exp, pred);
            errors++;
        end
        expected_q.push_back(typed ? typed_exp : pred);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_TX_DELAY) p_tx_delay = v;
        else p_rx_delay = v;
        @(negedge clk);
    endtask

    function automatic word_t mk(cmd_t c, logic ch, logic ctl, logic [7:0] d);
        word_t w;
        w.cmd = c;
        w.chan = ch;
        w.ctl = ctl;
        w.data = d;
        return w;
    endfunction

    // Directed table; typed rows hold outcomes readable at a glance
    row_t dir_rows [$];

    task automatic add_row(word_t w, logic typed, outcome_t e);
        row_t r;
        r.w = w;
        r.typed = typed;
        r.exp = e;
        dir_rows.push_back(r);
    endtask

    function automatic outcome_t rd_only(logic [7:0] v);
        outcome_t o;
        o = '0;
        o.rd = v;
        return o;
    endfunction

    // Random word generator: mostly well-formed traffic with random content
    function automatic word_t rand_word();
        int r;
        logic ch;
        r = $urandom_range(99);
        ch = 1'($urandom_range(1));
        if (r < 20) return mk(CMD_WRITE, ch, 1'b0, 8'($urandom_range(255)));
        if (r < 35) return mk(CMD_RECV, ch, 1'b0, 8'($urandom_range(255)));
        if (r < 65) return mk(CMD_TICK, ch, 1'($urandom_range(1)), 8'($urandom_range(255)));
        if (r < 78) return mk(CMD_READ, ch, 1'b0, 8'($urandom_range(255)));
        if (r < 90) return mk(CMD_READ, ch, 1'b1, 8'($urandom_range(255)));
        return mk(CMD_WRITE, ch, 1'b1, 8'($urandom_range(255)));
    endfunction

    initial
    begin
        outcome_t none;
        none = '0;
        predictor_reset();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // after reset: status reads and empty pops
        add_row(mk(CMD_READ, 1'b0, 1'b1, 8'h00), CHK_TYPED, rd_only(RR0_TX_EMPTY));
        add_row(mk(CMD_READ, 1'b1, 1'b0, 8'hff), CHK_TYPED, rd_only(8'h00));
        add_row(mk(CMD_TICK, 1'b0, 1'b0, 8'h00), CHK_TYPED, none);
        // pointer to RR1 and an unused register
        add_row(mk(CMD_WRITE, 1'b0, 1'b1, 8'h01), CHK_PRED, none);
        add_row(mk(CMD_READ, 1'b0, 1'b1, 8'h00), CHK_TYPED, rd_only(8'h01));
        add_row(mk(CMD_WRITE, 1'b1, 1'b1, 8'h07), CHK_PRED, none);
        add_row(mk(CMD_READ, 1'b1, 1'b1, 8'h00), CHK_TYPED, rd_only(RR_UNUSED));
        // vector base in channel B reg 2, interrupts enabled on both channels
        add_row(mk(CMD_WRITE, 1'b1, 1'b1, 8'h02), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b1, 1'b1, 8'hff), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b0, 1'b1, 8'h01), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b0, 1'b1, 8'h1e), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b1, 1'b1, 8'h01), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b1, 1'b1, 8'h1a), CHK_PRED, none);
        // transmit and receive on both channels, extremes of data
        add_row(mk(CMD_WRITE, 1'b0, 1'b0, 8'h00), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b1, 1'b0, 8'hff), CHK_PRED, none);
        add_row(mk(CMD_RECV, 1'b0, 1'b0, 8'ha5), CHK_PRED, none);
        add_row(mk(CMD_RECV, 1'b1, 1'b1, 8'h5a), CHK_PRED, none);
        add_row(mk(CMD_TICK, 1'b1, 1'b1, 8'hff), CHK_PRED, none);
        add_row(mk(CMD_READ, 1'b0, 1'b0, 8'h00), CHK_PRED, none);
        add_row(mk(CMD_READ, 1'b1, 1'b0, 8'h00), CHK_PRED, none);
        add_row(mk(CMD_WRITE, 1'b0, 1'b1, 8'h02), CHK_PRED, none);
        add_row(mk(CMD_READ, 1'b0, 1'b1, 8'h00), CHK_PRED, none);

        idle_pct = 0;
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
        drain();

        // full FIFOs: 20 writes and 20 receives per channel, then drain with ticks and bus pops
        idle_pct = 26;
        for (int i = 0; i < 40; i++)
        begin
            send_word(mk(CMD_WRITE, i[0], 1'b0, 8'($urandom_range(255))), CHK_PRED, none);
            send_word(mk(CMD_RECV, i[0], 1'b0, 8'($urandom_range(255))), CHK_PRED, none);
        end
        for (int i = 0; i < 40; i++)
            send_word(mk(CMD_TICK, 1'b0, 1'b0, 8'h00), CHK_PRED, none);
        for (int i = 0; i < 20; i++)
            send_word(mk(CMD_READ, i[0], 1'b0, 8'h00), CHK_PRED, none);
        // sender waits for every result before going on
        drain();

        // random phases under several delay settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_cfg(REG_TX_DELAY, 16'd1); write_cfg(REG_RX_DELAY, 16'd1); end
                1: begin write_cfg(REG_TX_DELAY, 16'd3); write_cfg(REG_RX_DELAY, 16'd2); end
                2: begin write_cfg(REG_TX_DELAY, 16'd0); write_cfg(REG_RX_DELAY, 16'd5); end
                3: begin write_cfg(REG_TX_DELAY, 16'hffff); write_cfg(REG_RX_DELAY, 16'hffff); end
                default:
                begin
                    write_cfg(REG_TX_DELAY, 16'($urandom_range(1, 4)));
                    write_cfg(REG_RX_DELAY, 16'($urandom_range(1, 4)));
                end
            endcase
            // phase 1 runs without any idling on either side
            idle_pct = (ph == 1) ? 0 : 26;
            hold_off = (ph == 1);
            for (int i = 0; i < 58; i++)
                send_word(rand_word(), CHK_PRED, none);
            hold_off = 0;
            drain();
        end

        repeat (10) @(negedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS dual_serial_channel_controller_unit");
        else
            $display("FAIL dual_serial_channel_controller_unit");
        $finish;
    end
endmodule
